[rtl/tsc_pkg.sv]
`default_nettype none

package tsc_pkg;

  localparam int KIND_W = 3;
  localparam int VAR_W  = 9;
  localparam int NV_W   = 9;

  localparam int DEF_MAX_VARS  = 256;
  localparam int DEF_MAX_EDGES = 2048;

  localparam logic [KIND_W-1:0] KIND_NOT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_XOR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_IMP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_AND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OR  = 3'd4;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_CLEAR  = 5'd0;
  localparam logic [ST_W-1:0] ST_IDLE   = 5'd1;
  localparam logic [ST_W-1:0] ST_EVAL   = 5'd2;
  localparam logic [ST_W-1:0] ST_EREAD  = 5'd3;
  localparam logic [ST_W-1:0] ST_EWRITE = 5'd4;
  localparam logic [ST_W-1:0] ST_LCLR1  = 5'd5;
  localparam logic [ST_W-1:0] ST_P1RD   = 5'd6;
  localparam logic [ST_W-1:0] ST_P1TST  = 5'd7;
  localparam logic [ST_W-1:0] ST_LCLR2  = 5'd8;
  localparam logic [ST_W-1:0] ST_P2RD   = 5'd9;
  localparam logic [ST_W-1:0] ST_P2LAB  = 5'd10;
  localparam logic [ST_W-1:0] ST_P2TST  = 5'd11;
  localparam logic [ST_W-1:0] ST_WHEAD  = 5'd12;
  localparam logic [ST_W-1:0] ST_WEDGE  = 5'd13;
  localparam logic [ST_W-1:0] ST_WPOP   = 5'd14;
  localparam logic [ST_W-1:0] ST_WREAD  = 5'd15;
  localparam logic [ST_W-1:0] ST_WLAB   = 5'd16;
  localparam logic [ST_W-1:0] ST_FRD0   = 5'd17;
  localparam logic [ST_W-1:0] ST_FRD1   = 5'd18;
  localparam logic [ST_W-1:0] ST_FCMP   = 5'd19;
  localparam logic [ST_W-1:0] ST_DONE   = 5'd20;

  typedef struct packed {
    logic [ST_W-1:0] op;
    logic            accept;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic add_edges;
    logic more_edges;
    logic last;
    logic scan_end;
    logic label_zero;
    logic push_ok;
    logic ptr_nil;
    logic sp_one;
    logic pass;
    logic order_empty;
    logic check_end;
    logic labels_equal;
  } sts_t;

endpackage

`default_nettype wire

[rtl/tsc_ctrl.sv]
`default_nettype none

module tsc_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  input  tsc_pkg::sts_t   sts,
  output tsc_pkg::cmd_t   cmd,
  output logic            busy
);
  import tsc_pkg::*;

  logic [ST_W-1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (sts.sweep_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (sts.add_edges) state_nxt = ST_EREAD;
        else if (sts.last) state_nxt = ST_LCLR1;
        else state_nxt = ST_IDLE;
      end
      ST_EREAD:  state_nxt = ST_EWRITE;
      ST_EWRITE: begin
        if (sts.more_edges) state_nxt = ST_EREAD;
        else if (sts.last) state_nxt = ST_LCLR1;
        else state_nxt = ST_IDLE;
      end
      ST_LCLR1:  if (sts.sweep_last) state_nxt = ST_P1RD;
      ST_P1RD:   state_nxt = sts.scan_end ? ST_LCLR2 : ST_P1TST;
      ST_P1TST:  state_nxt = sts.label_zero ? ST_WHEAD : ST_P1RD;
      ST_LCLR2:  if (sts.sweep_last) state_nxt = ST_P2RD;
      ST_P2RD:   state_nxt = sts.order_empty ? ST_FRD0 : ST_P2LAB;
      ST_P2LAB:  state_nxt = ST_P2TST;
      ST_P2TST:  state_nxt = sts.label_zero ? ST_WHEAD : ST_P2RD;
      ST_WHEAD:  state_nxt = ST_WEDGE;
      ST_WEDGE: begin
        if (!sts.ptr_nil) state_nxt = ST_WREAD;
        else if (!sts.sp_one) state_nxt = ST_WPOP;
        else state_nxt = sts.pass ? ST_P2RD : ST_P1RD;
      end
      ST_WPOP:   state_nxt = ST_WEDGE;
      ST_WREAD:  state_nxt = ST_WLAB;
      ST_WLAB:   state_nxt = sts.push_ok ? ST_WHEAD : ST_WEDGE;
      ST_FRD0:   state_nxt = sts.check_end ? ST_DONE : ST_FRD1;
      ST_FRD1:   state_nxt = ST_FCMP;
      ST_FCMP:   state_nxt = sts.labels_equal ? ST_DONE : ST_FRD0;
      ST_DONE:   state_nxt = ST_CLEAR;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  assign cmd.op     = state_r;
  assign cmd.accept = (state_r == ST_IDLE) && start;
  assign busy       = (state_r != ST_IDLE);

endmodule

`default_nettype wire

[rtl/tsc_dp.sv]
`default_nettype none

module tsc_dp #(
  parameter int MAX_VARS  = tsc_pkg::DEF_MAX_VARS,
  parameter int MAX_EDGES = tsc_pkg::DEF_MAX_EDGES
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  tsc_pkg::cmd_t                cmd,
  output tsc_pkg::sts_t                sts,
  input  wire [tsc_pkg::KIND_W-1:0]    in_kind,
  input  wire [tsc_pkg::VAR_W-1:0]     in_var_a,
  input  wire [tsc_pkg::VAR_W-1:0]     in_var_b,
  input  wire                          in_last,
  input  wire [tsc_pkg::NV_W-1:0]      num_vars,
  output logic                         out_valid,
  output logic                         out_satisfiable,
  output logic                         out_error
);
  import tsc_pkg::*;

  localparam int NODES = 2 * MAX_VARS;
  localparam int NW    = $clog2(NODES);
  localparam int SPW   = $clog2(NODES + 1);
  localparam int LW    = SPW;
  localparam int XW    = $clog2(MAX_VARS + 1);
  localparam int EAW   = $clog2(MAX_EDGES);
  localparam int PW    = $clog2(MAX_EDGES + 1);
  localparam int EW    = NW + PW;
  localparam logic [PW-1:0] NIL = PW'(MAX_EDGES);

  // memories
  logic [PW-1:0] fwd_head_mem [NODES];
  logic [PW-1:0] rev_head_mem [NODES];
  logic [EW-1:0] fwd_edge_mem [MAX_EDGES];
  logic [EW-1:0] rev_edge_mem [MAX_EDGES];
  logic [LW-1:0] label_mem    [NODES];
  logic [NW-1:0] order_mem    [NODES];
  logic [EW-1:0] stack_mem    [NODES];

  // clause and walk registers
  logic [KIND_W-1:0] kind_r;
  logic [VAR_W-1:0]  a_r, b_r;
  logic              last_r;
  logic [XW-1:0]     nv_r;
  logic [1:0]        j_r;
  logic [PW-1:0]     ec_r;
  logic              err_r;
  logic [LW-1:0]     comp_r;
  logic              pass_r;
  logic [NW-1:0]     clr_r;
  logic [SPW-1:0]    scan_r, fc_r, ord_r, sp_r;
  logic              sat_r;
  logic [XW-1:0]     x_r;
  logic [NW-1:0]     top_node_r, t_r, n_r;
  logic [PW-1:0]     top_ptr_r;
  logic [LW-1:0]     lbl_r, lab0_r;

  // memory ports
  logic          fh_we, rh_we, e_we, lb_we, od_we, sk_we;
  logic [NW-1:0] fh_wa, rh_wa, fh_ra, rh_ra, lb_wa, lb_ra, od_wa, od_ra, sk_wa, sk_ra;
  logic [PW-1:0] fh_wd, rh_wd, fh_rd, rh_rd;
  logic [EAW-1:0] e_wa, e_ra;
  logic [EW-1:0] fe_wd, re_wd, fe_rd, re_rd, sk_wd, sk_rd;
  logic [LW-1:0] lb_wd, lb_rd;
  logic [NW-1:0] od_wd, od_rd;

  // clause decode
  logic [31:0]   a_ext, b_ext, ap32, bp32;
  logic [NW-1:0] ap_n, an_n, bp_n, bn_n;
  logic          ok_a, ok_b, bad;
  logic [2:0]    k;
  logic          fits;
  logic [NW-1:0] src_e [4];
  logic [NW-1:0] dst_e [4];
  logic [NW-1:0] src_sel, dst_sel;
  logic [XW-1:0] nv_cap;

  logic [EW-1:0]  edge_rd;
  logic [NW-1:0]  edge_to;
  logic [PW-1:0]  edge_next, head_rd;
  logic [NW-1:0]  scan_node, walk_node, node2x;
  logic [SPW-1:0] ord_m1, sp_m1, sp_m2;
  logic           sweep_last, label_zero, push_ok, ptr_nil, rec_ok;

  assign a_ext = {{(32-VAR_W){1'b0}}, a_r};
  assign b_ext = {{(32-VAR_W){1'b0}}, b_r};
  assign ap32  = (a_ext << 1) - 32'd2;
  assign bp32  = (b_ext << 1) - 32'd2;
  assign ap_n  = ap32[NW-1:0];
  assign bp_n  = bp32[NW-1:0];
  assign an_n  = ap_n + NW'(1);
  assign bn_n  = bp_n + NW'(1);
  assign ok_a  = (a_r != '0) && (a_ext <= 32'(nv_r));
  assign ok_b  = (b_r != '0) && (b_ext <= 32'(nv_r));

  assign nv_cap = (32'(num_vars) > 32'(MAX_VARS)) ? XW'(MAX_VARS) : XW'(num_vars);

  always_comb begin
    k   = 3'd0;
    bad = 1'b0;
    for (int i = 0; i < 4; i++) begin
      src_e[i] = '0;
      dst_e[i] = '0;
    end
    case (kind_r)
      KIND_NOT: begin
        if (ok_a) begin
          src_e[0] = ap_n; dst_e[0] = an_n; k = 3'd1;
        end else begin
          bad = 1'b1;
        end
      end
      KIND_XOR: begin
        if (ok_a && ok_b) begin
          src_e[0] = an_n; dst_e[0] = bp_n;
          src_e[1] = bn_n; dst_e[1] = ap_n;
          src_e[2] = ap_n; dst_e[2] = bn_n;
          src_e[3] = bp_n; dst_e[3] = an_n;
          k = 3'd4;
        end else begin
          bad = 1'b1;
        end
      end
      KIND_IMP: begin
        if (ok_a && ok_b) begin
          src_e[0] = ap_n; dst_e[0] = bp_n;
          src_e[1] = bn_n; dst_e[1] = an_n;
          k = 3'd2;
        end else begin
          bad = 1'b1;
        end
      end
      KIND_AND: begin
        if (ok_a && ok_b) begin
          src_e[0] = an_n; dst_e[0] = ap_n;
          src_e[1] = bn_n; dst_e[1] = bp_n;
          k = 3'd2;
        end else begin
          bad = 1'b1;
        end
      end
      KIND_OR: begin
        if (ok_a && ok_b) begin
          src_e[0] = an_n; dst_e[0] = bp_n;
          src_e[1] = bn_n; dst_e[1] = ap_n;
          k = 3'd2;
        end else begin
          bad = 1'b1;
        end
      end
      default: k = 3'd0;
    endcase
  end

  assign fits    = (32'(ec_r) + 32'(k)) <= 32'(MAX_EDGES);
  assign src_sel = src_e[j_r];
  assign dst_sel = dst_e[j_r];

  assign edge_rd    = pass_r ? fe_rd : re_rd;
  assign edge_to    = edge_rd[EW-1:PW];
  assign edge_next  = edge_rd[PW-1:0];
  assign head_rd    = pass_r ? fh_rd : rh_rd;
  assign scan_node  = scan_r[NW-1:0];
  assign node2x     = NW'({x_r, 1'b0});
  assign ord_m1     = ord_r - SPW'(1);
  assign sp_m1      = sp_r - SPW'(1);
  assign sp_m2      = sp_r - SPW'(2);
  assign sweep_last = (clr_r == NW'(NODES - 1));
  assign label_zero = (lb_rd == '0);
  assign push_ok    = label_zero && (sp_r < SPW'(NODES));
  assign ptr_nil    = 32'(top_ptr_r) >= 32'(MAX_EDGES);
  assign rec_ok     = !pass_r && (fc_r < SPW'(NODES));

  always_comb begin
    case (cmd.op)
      ST_P2TST: walk_node = n_r;
      ST_WLAB:  walk_node = t_r;
      default:  walk_node = scan_node;
    endcase
  end

  // memory port steering
  always_comb begin
    fh_we = 1'b0; fh_wa = src_sel; fh_wd = ec_r;
    rh_we = 1'b0; rh_wa = dst_sel; rh_wd = ec_r;
    fh_ra = (cmd.op == ST_EREAD) ? src_sel : walk_node;
    rh_ra = (cmd.op == ST_EREAD) ? dst_sel : walk_node;
    e_we  = 1'b0;
    e_wa  = ec_r[EAW-1:0];
    fe_wd = {dst_sel, fh_rd};
    re_wd = {src_sel, rh_rd};
    e_ra  = top_ptr_r[EAW-1:0];
    lb_we = 1'b0; lb_wa = clr_r; lb_wd = '0;
    lb_ra = scan_node;
    od_we = 1'b0; od_wa = fc_r[NW-1:0]; od_wd = top_node_r;
    od_ra = ord_m1[NW-1:0];
    sk_we = 1'b0; sk_wa = sp_m1[NW-1:0]; sk_wd = {top_node_r, top_ptr_r};
    sk_ra = sp_m2[NW-1:0];
    case (cmd.op)
      ST_CLEAR: begin
        fh_we = 1'b1; fh_wa = clr_r; fh_wd = NIL;
        rh_we = 1'b1; rh_wa = clr_r; rh_wd = NIL;
        lb_we = 1'b1;
      end
      ST_EWRITE: begin
        fh_we = 1'b1;
        rh_we = 1'b1;
        e_we  = 1'b1;
      end
      ST_LCLR1, ST_LCLR2: lb_we = 1'b1;
      ST_P1TST: begin
        lb_we = label_zero; lb_wa = scan_node; lb_wd = LW'(1);
      end
      ST_P2LAB: lb_ra = od_rd;
      ST_P2TST: begin
        lb_we = label_zero; lb_wa = n_r; lb_wd = comp_r + LW'(1);
      end
      ST_WEDGE: od_we = ptr_nil && rec_ok;
      ST_WREAD: lb_ra = edge_to;
      ST_WLAB: begin
        lb_we = push_ok; lb_wa = t_r; lb_wd = lbl_r;
        sk_we = push_ok;
      end
      ST_FRD0: lb_ra = node2x;
      ST_FRD1: lb_ra = node2x + NW'(1);
      default: lb_ra = scan_node;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fh_we) fwd_head_mem[fh_wa] <= fh_wd;
    fh_rd <= fwd_head_mem[fh_ra];
  end

  always_ff @(posedge clk) begin
    if (rh_we) rev_head_mem[rh_wa] <= rh_wd;
    rh_rd <= rev_head_mem[rh_ra];
  end

  always_ff @(posedge clk) begin
    if (e_we) fwd_edge_mem[e_wa] <= fe_wd;
    fe_rd <= fwd_edge_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (e_we) rev_edge_mem[e_wa] <= re_wd;
    re_rd <= rev_edge_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (lb_we) label_mem[lb_wa] <= lb_wd;
    lb_rd <= label_mem[lb_ra];
  end

  always_ff @(posedge clk) begin
    if (od_we) order_mem[od_wa] <= od_wd;
    od_rd <= order_mem[od_ra];
  end

  always_ff @(posedge clk) begin
    if (sk_we) stack_mem[sk_wa] <= sk_wd;
    sk_rd <= stack_mem[sk_ra];
  end

  // counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      ec_r   <= '0;
      err_r  <= 1'b0;
      comp_r <= '0;
      pass_r <= 1'b0;
      scan_r <= '0;
      fc_r   <= '0;
      ord_r  <= '0;
      sp_r   <= '0;
      sat_r  <= 1'b0;
      x_r    <= '0;
      j_r    <= '0;
    end else begin
      case (cmd.op)
        ST_CLEAR: begin
          clr_r  <= sweep_last ? '0 : clr_r + NW'(1);
          ec_r   <= '0;
          err_r  <= 1'b0;
          comp_r <= '0;
        end
        ST_IDLE: j_r <= '0;
        ST_EVAL: if (bad || ((k != 3'd0) && !fits)) err_r <= 1'b1;
        ST_EWRITE: begin
          ec_r <= ec_r + PW'(1);
          j_r  <= j_r + 2'd1;
        end
        ST_LCLR1: begin
          clr_r  <= sweep_last ? '0 : clr_r + NW'(1);
          pass_r <= 1'b0;
          fc_r   <= '0;
          scan_r <= '0;
        end
        ST_LCLR2: begin
          clr_r  <= sweep_last ? '0 : clr_r + NW'(1);
          pass_r <= 1'b1;
          comp_r <= '0;
          ord_r  <= fc_r;
        end
        ST_P1TST: begin
          scan_r <= scan_r + SPW'(1);
          if (label_zero) sp_r <= SPW'(1);
        end
        ST_P2RD: begin
          if (ord_r == '0) begin
            sat_r <= 1'b1;
            x_r   <= '0;
          end else begin
            ord_r <= ord_m1;
          end
        end
        ST_P2TST: begin
          if (label_zero) begin
            comp_r <= comp_r + LW'(1);
            sp_r   <= SPW'(1);
          end
        end
        ST_WEDGE: begin
          if (ptr_nil) begin
            if (rec_ok) fc_r <= fc_r + SPW'(1);
            sp_r <= sp_m1;
          end
        end
        ST_WLAB: if (push_ok) sp_r <= sp_r + SPW'(1);
        ST_FCMP: begin
          if (lab0_r == lb_rd) sat_r <= 1'b0;
          else x_r <= x_r + XW'(1);
        end
        default: j_r <= j_r;
      endcase
    end
  end

  // clause and walk frame
  always_ff @(posedge clk) begin
    case (cmd.op)
      ST_IDLE: begin
        if (cmd.accept) begin
          kind_r <= in_kind;
          a_r    <= in_var_a;
          b_r    <= in_var_b;
          last_r <= in_last;
          nv_r   <= nv_cap;
        end
      end
      ST_P1TST: begin
        if (label_zero) begin
          top_node_r <= scan_node;
          lbl_r      <= LW'(1);
        end
      end
      ST_P2LAB: n_r <= od_rd;
      ST_P2TST: begin
        if (label_zero) begin
          top_node_r <= n_r;
          lbl_r      <= comp_r + LW'(1);
        end
      end
      ST_WHEAD: top_ptr_r <= head_rd;
      ST_WPOP:  {top_node_r, top_ptr_r} <= sk_rd;
      ST_WREAD: begin
        t_r       <= edge_to;
        top_ptr_r <= edge_next;
      end
      ST_WLAB:  if (push_ok) top_node_r <= t_r;
      ST_FRD1:  lab0_r <= lb_rd;
      default:  lab0_r <= lab0_r;
    endcase
  end

  assign sts.sweep_last   = sweep_last;
  assign sts.add_edges    = (k != 3'd0) && fits;
  assign sts.more_edges   = ({1'b0, j_r} + 3'd1) < k;
  assign sts.last         = last_r;
  assign sts.scan_end     = (scan_r == SPW'(NODES));
  assign sts.label_zero   = label_zero;
  assign sts.push_ok      = push_ok;
  assign sts.ptr_nil      = ptr_nil;
  assign sts.sp_one       = (sp_r == SPW'(1));
  assign sts.pass         = pass_r;
  assign sts.order_empty  = (ord_r == '0);
  assign sts.check_end    = (x_r == nv_r);
  assign sts.labels_equal = (lab0_r == lb_rd);

  assign out_valid       = (cmd.op == ST_DONE);
  assign out_satisfiable = sat_r;
  assign out_error       = err_r;

endmodule

`default_nettype wire

[rtl/two_sat_checker.sv]
// Channel   Handshake                     Payload
// input     start (taken when !busy)      in_kind, in_var_a, in_var_b, in_last
// result    out_valid (one-cycle strobe)  out_satisfiable, out_error
// config    psel/penable/pwrite, pready=1 paddr, pwdata, prdata (num_vars at 0)
//
// A clause is evaluated and then, if it is valid and fits, writes its
// implication edges. A last item adds the check: two label sweeps over
// 2*MAX_VARS nodes, a depth-first pass over each graph, and a final compare
// per variable. A clearing sweep over 2*MAX_VARS nodes follows reset and
// each result with busy high. Reset is synchronous, active low. Results
// cannot stall.
`default_nettype none

module two_sat_checker #(
  parameter int MAX_VARS  = tsc_pkg::DEF_MAX_VARS,
  parameter int MAX_EDGES = tsc_pkg::DEF_MAX_EDGES
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire [tsc_pkg::KIND_W-1:0]  in_kind,
  input  wire [tsc_pkg::VAR_W-1:0]   in_var_a,
  input  wire [tsc_pkg::VAR_W-1:0]   in_var_b,
  input  wire                        in_last,
  output logic                       out_valid,
  output logic                       out_satisfiable,
  output logic                       out_error,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [1:0]                  paddr,
  input  wire [31:0]                 pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tsc_pkg::*;

  localparam logic [1:0] ADDR_NUM_VARS = 2'd0;

  logic [NV_W-1:0] num_vars_r;
  cmd_t            cmd;
  sts_t            sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= NV_W'(1);
    end else if (psel && penable && pwrite && (paddr == ADDR_NUM_VARS)) begin
      num_vars_r <= pwdata[NV_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NUM_VARS) ? {{(32-NV_W){1'b0}}, num_vars_r} : 32'd0;

  tsc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tsc_dp #(
    .MAX_VARS  (MAX_VARS),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_var_a        (in_var_a),
    .in_var_b        (in_var_b),
    .in_last         (in_last),
    .num_vars        (num_vars_r),
    .out_valid       (out_valid),
    .out_satisfiable (out_satisfiable),
    .out_error       (out_error)
  );

endmodule

`default_nettype wire
